// ===== design/hcs_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hcs_pkg: shared constants and types for the HSL color shade pipeline
// Fixed-point formats, divider sizing and the word carried alongside
// the divider stages.
// ---------------------------------------------------------------------------
package hcs_pkg;

    localparam int CH_W      = 8;   // color channel width
    localparam int FACT_W    = 10;  // shade factor width, Q2.8
    localparam int FACT_FRAC = 8;
    localparam int FRAC      = 16;  // fraction bits of unit values
    localparam int UNIT_W    = FRAC + 1;  // holds 0..ONE inclusive

    localparam logic [UNIT_W-1:0] ONE        = UNIT_W'(1) << FRAC;
    localparam logic [UNIT_W-1:0] HALF       = UNIT_W'(1) << (FRAC - 1);
    localparam logic [UNIT_W-1:0] THIRD      = UNIT_W'((2 ** FRAC) / 3);
    localparam logic [UNIT_W-1:0] TWO_THIRDS = UNIT_W'((2 * (2 ** FRAC)) / 3);

    // restoring divider: quotient below 2**DIV_Q_W, numerator top part below divisor
    localparam int DIV_Q_W   = UNIT_W;
    localparam int DIV_DEN_W = UNIT_W + 1;
    localparam int DIV_NUM_W = DIV_Q_W + FRAC;

    // hue in degrees, Q16
    localparam int DEG_W = 25;
    localparam logic [DEG_W-1:0] DEG_120 = DEG_W'(120 * (2 ** FRAC));
    localparam logic [DEG_W-1:0] DEG_240 = DEG_W'(240 * (2 ** FRAC));
    localparam logic [DEG_W-1:0] DEG_360 = DEG_W'(360 * (2 ** FRAC));

    // degrees to turns: ((deg >> 3) * TURN_RECIP) >> TURN_SHIFT == deg / 360,
    // exact for every deg below 360 degrees
    localparam int TURN_SHIFT   = 28;
    localparam int TURN_RECIP_W = 23;
    localparam logic [TURN_RECIP_W-1:0] TURN_RECIP = TURN_RECIP_W'(5965233); // ceil(2**28/45)

    // which channel holds the maximum
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // per-pixel word that rides along the divider stages
    typedef struct packed {
        logic [CH_W-1:0]   alpha;
        logic [FACT_W-1:0] fac;
        logic [UNIT_W-1:0] l;
        logic [UNIT_W-1:0] s;
        logic [UNIT_W-1:0] dmag;
        logic [UNIT_W-1:0] delta;
        logic              neg;
        t_sector           sec;
    } t_side;

endpackage
`default_nettype wire

// ===== design/hcs_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hcs_div: pipelined restoring divider
// One quotient bit per stage; a side word travels with each division.
// ---------------------------------------------------------------------------
module hcs_div import hcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [DIV_Q_W-1:0]   o_quo,
    output t_side                o_side
);

    typedef struct packed {
        logic [DIV_DEN_W-1:0] rem;
        logic [DIV_Q_W-1:0]   low;
        logic [DIV_Q_W-1:0]   quo;
        logic [DIV_DEN_W-1:0] den;
        t_side                side;
    } t_dstg;

    t_dstg              w_in [DIV_Q_W];
    t_dstg              n_st [DIV_Q_W];
    t_dstg              r_st [DIV_Q_W];
    logic [DIV_Q_W-1:0] r_vld;

    always_comb begin
        logic [DIV_DEN_W:0] t;
        logic [DIV_DEN_W:0] sub;
        logic               ge;
        w_in[0].rem  = DIV_DEN_W'(i_num[DIV_NUM_W-1:DIV_Q_W]);
        w_in[0].low  = i_num[DIV_Q_W-1:0];
        w_in[0].quo  = '0;
        w_in[0].den  = i_den;
        w_in[0].side = i_side;
        for (int k = 1; k < DIV_Q_W; k++) begin
            w_in[k] = r_st[k-1];
        end
        for (int k = 0; k < DIV_Q_W; k++) begin
            t   = {w_in[k].rem, w_in[k].low[DIV_Q_W-1]};
            sub = t - {1'b0, w_in[k].den};
            ge  = (t >= {1'b0, w_in[k].den});
            n_st[k]     = w_in[k];
            n_st[k].rem = ge ? sub[DIV_DEN_W-1:0] : t[DIV_DEN_W-1:0];
            n_st[k].low = {w_in[k].low[DIV_Q_W-2:0], 1'b0};
            n_st[k].quo = {w_in[k].quo[DIV_Q_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_Q_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_Q_W; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_valid = r_vld[DIV_Q_W-1];
    assign o_quo   = r_st[DIV_Q_W-1].quo;
    assign o_side  = r_st[DIV_Q_W-1].side;

endmodule
`default_nettype wire

// ===== design/hcs_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hcs_front: RGB to unit values, max/min, lightness, saturation operands
// Three register stages; output feeds the saturation divider.
// ---------------------------------------------------------------------------
module hcs_front import hcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [CH_W-1:0]      i_red,
    input  logic [CH_W-1:0]      i_green,
    input  logic [CH_W-1:0]      i_blue,
    input  logic [CH_W-1:0]      i_alpha,
    input  logic [FACT_W-1:0]    i_fac,
    output logic                 o_valid,
    output logic [DIV_NUM_W-1:0] o_num,
    output logic [DIV_DEN_W-1:0] o_den,
    output t_side                o_side
);

    localparam logic [DIV_DEN_W-1:0] TWO_ONE = DIV_DEN_W'(2) << FRAC;

    logic [2:0] r_vld;

    // stage 1: c * 65535 / 255 == 257 * c, plus one for full scale
    logic [UNIT_W-1:0] n_r, n_g, n_b;
    logic [UNIT_W-1:0] r_r, r_g, r_b;
    logic [CH_W-1:0]   r1_alpha;
    logic [FACT_W-1:0] r1_fac;

    assign n_r = {1'b0, i_red, i_red} + UNIT_W'(&i_red);
    assign n_g = {1'b0, i_green, i_green} + UNIT_W'(&i_green);
    assign n_b = {1'b0, i_blue, i_blue} + UNIT_W'(&i_blue);

    // stage 2: extremes, sector, signed hue difference
    logic [UNIT_W-1:0]        n_mx, n_mn;
    t_sector                  n_sec;
    logic signed [UNIT_W:0]   n_diff;
    logic [UNIT_W-1:0]        r_mx, r_mn;
    t_sector                  r_sec;
    logic signed [UNIT_W:0]   r_diff;
    logic [CH_W-1:0]          r2_alpha;
    logic [FACT_W-1:0]        r2_fac;

    always_comb begin
        n_mx = (r_r > r_g) ? r_r : r_g;
        if (r_b > n_mx) begin
            n_mx = r_b;
        end
        n_mn = (r_r < r_g) ? r_r : r_g;
        if (r_b < n_mn) begin
            n_mn = r_b;
        end
        // ties: red over green over blue
        if (r_r >= r_g && r_r >= r_b) begin
            n_sec  = SEC_RED;
            n_diff = $signed({1'b0, r_g}) - $signed({1'b0, r_b});
        end else if (r_g >= r_b) begin
            n_sec  = SEC_GREEN;
            n_diff = $signed({1'b0, r_b}) - $signed({1'b0, r_r});
        end else begin
            n_sec  = SEC_BLUE;
            n_diff = $signed({1'b0, r_r}) - $signed({1'b0, r_g});
        end
    end

    // stage 3: lightness and the saturation division operands
    logic [DIV_DEN_W-1:0] n_sum;
    logic [UNIT_W-1:0]    n_l, n_delta, n_dmag;
    logic                 n_neg;
    logic [DIV_NUM_W-1:0] n_num;
    logic [DIV_DEN_W-1:0] n_den;
    t_side                n_side;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    t_side                r_side;

    always_comb begin
        n_sum   = {1'b0, r_mx} + {1'b0, r_mn};
        n_l     = n_sum[UNIT_W:1];
        n_delta = r_mx - r_mn;
        n_neg   = r_diff[UNIT_W];
        n_dmag  = n_neg ? UNIT_W'(-r_diff) : r_diff[UNIT_W-1:0];
        if (n_delta == '0) begin
            // grey: saturation forced to zero
            n_num = '0;
            n_den = DIV_DEN_W'(1);
        end else if (n_l <= HALF) begin
            n_num = {n_delta, {FRAC{1'b0}}};
            n_den = n_sum;
        end else begin
            n_num = {n_delta, {FRAC{1'b0}}};
            n_den = TWO_ONE - n_sum;
        end
        n_side.alpha = r2_alpha;
        n_side.fac   = r2_fac;
        n_side.l     = n_l;
        n_side.s     = '0;
        n_side.dmag  = n_dmag;
        n_side.delta = n_delta;
        n_side.neg   = n_neg;
        n_side.sec   = r_sec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r      <= n_r;
            r_g      <= n_g;
            r_b      <= n_b;
            r1_alpha <= i_alpha;
            r1_fac   <= i_fac;
            r_mx     <= n_mx;
            r_mn     <= n_mn;
            r_sec    <= n_sec;
            r_diff   <= n_diff;
            r2_alpha <= r1_alpha;
            r2_fac   <= r1_fac;
            r_num    <= n_num;
            r_den    <= n_den;
            r_side   <= n_side;
        end
    end

    assign o_valid = r_vld[2];
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule
`default_nettype wire

// ===== design/hcs_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hcs_back: shade lightness/saturation and convert HSL back to RGB
// Seven register stages, the last one is the output register.
// ---------------------------------------------------------------------------
module hcs_back import hcs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [UNIT_W-1:0] i_turn,
    output logic              o_valid,
    output logic [CH_W-1:0]   o_red,
    output logic [CH_W-1:0]   o_green,
    output logic [CH_W-1:0]   o_blue,
    output logic [CH_W-1:0]   o_alpha
);

    localparam int PW = UNIT_W + FACT_W;
    localparam int XW = UNIT_W + CH_W + 1;
    localparam logic [CH_W-1:0] MAXC = '1;

    typedef enum logic [1:0] {
        SEG_RAMP,
        SEG_Q,
        SEG_P
    } t_seg;

    function automatic logic [CH_W-1:0] to_chan(input logic [UNIT_W:0] v);
        logic [XW-1:0]      x;
        logic [XW-FRAC-1:0] r;
        x = {v, {CH_W{1'b0}}} - XW'(v) + XW'(HALF);
        r = x[XW-1:FRAC];
        return (r > (XW-FRAC)'(MAXC)) ? MAXC : r[CH_W-1:0];
    endfunction

    logic [6:0] r_vld;

    // stage 1: scale and clamp
    logic [PW-1:0]     n1_lp, n1_sp;
    logic [UNIT_W-1:0] n1_l, n1_s;
    logic [UNIT_W-1:0] r1_l, r1_s, r1_turn;
    logic [CH_W-1:0]   r1_alpha;

    always_comb begin
        n1_lp = PW'(i_side.l) * PW'(i_side.fac);
        n1_sp = PW'(i_side.s) * PW'(i_side.fac);
        n1_l  = (n1_lp[PW-1:FACT_FRAC] > (PW-FACT_FRAC)'(ONE)) ? ONE
              : n1_lp[UNIT_W+FACT_FRAC-1:FACT_FRAC];
        n1_s  = (n1_sp[PW-1:FACT_FRAC] > (PW-FACT_FRAC)'(ONE)) ? ONE
              : n1_sp[UNIT_W+FACT_FRAC-1:FACT_FRAC];
    end

    // stage 2: l * s
    logic [2*UNIT_W-1:0] n2_prod;
    logic [UNIT_W-1:0]   r2_ls, r2_l, r2_s, r2_turn;
    logic [CH_W-1:0]     r2_alpha;

    assign n2_prod = r1_l * r1_s;

    // stage 3: q, p and the three hue offsets
    logic [UNIT_W:0]          n3_q;
    logic signed [UNIT_W+1:0] n3_p;
    logic [UNIT_W:0]          n3_tr;
    logic [UNIT_W-1:0]        n3_t [3];
    logic [UNIT_W-1:0]        r3_q, r3_p, r3_l;
    logic [UNIT_W-1:0]        r3_t [3];
    logic                     r3_szero;
    logic [CH_W-1:0]          r3_alpha;

    always_comb begin
        if (r2_l <= HALF) begin
            n3_q = {1'b0, r2_l} + {1'b0, r2_ls};
        end else begin
            n3_q = {1'b0, r2_l} + {1'b0, r2_s} - {1'b0, r2_ls};
        end
        n3_p = $signed({1'b0, r2_l, 1'b0}) - $signed({1'b0, n3_q});
        if (n3_p < 0) begin
            n3_p = '0;
        end
        n3_tr   = {1'b0, r2_turn} + {1'b0, THIRD};
        n3_t[0] = (n3_tr > {1'b0, ONE}) ? UNIT_W'(n3_tr - {1'b0, ONE}) : n3_tr[UNIT_W-1:0];
        n3_t[1] = r2_turn;
        n3_t[2] = (r2_turn >= THIRD) ? (r2_turn - THIRD) : (r2_turn + (ONE - THIRD));
    end

    // stage 4: hue segment and ramp weight per channel
    localparam int W6 = UNIT_W + 3;
    logic [W6-1:0]     n4_t6  [3];
    logic [W6-1:0]     n4_t3  [3];
    logic [W6-1:0]     n4_dd6 [3];
    logic [UNIT_W-1:0] n4_dd  [3];
    logic [UNIT_W-1:0] n4_w   [3];
    t_seg              n4_seg [3];
    logic [UNIT_W-1:0] r4_w   [3];
    t_seg              r4_seg [3];
    logic [UNIT_W-1:0] r4_d, r4_p, r4_q, r4_l;
    logic              r4_szero;
    logic [CH_W-1:0]   r4_alpha;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n4_t6[c]  = (W6'(r3_t[c]) << 2) + (W6'(r3_t[c]) << 1);
            n4_t3[c]  = (W6'(r3_t[c]) << 1) + W6'(r3_t[c]);
            n4_dd[c]  = TWO_THIRDS - r3_t[c];
            n4_dd6[c] = (W6'(n4_dd[c]) << 2) + (W6'(n4_dd[c]) << 1);
            if (n4_t6[c] < W6'(ONE)) begin
                n4_seg[c] = SEG_RAMP;
                n4_w[c]   = n4_t6[c][UNIT_W-1:0];
            end else if ({r3_t[c], 1'b0} < {1'b0, ONE}) begin
                n4_seg[c] = SEG_Q;
                n4_w[c]   = '0;
            end else if (n4_t3[c] < (W6'(ONE) << 1)) begin
                n4_seg[c] = SEG_RAMP;
                n4_w[c]   = n4_dd6[c][UNIT_W-1:0];
            end else begin
                n4_seg[c] = SEG_P;
                n4_w[c]   = '0;
            end
        end
    end

    // stage 5: ramp product
    logic [2*UNIT_W-1:0] n5_prod [3];
    logic [UNIT_W-1:0]   r5_hp   [3];
    t_seg                r5_seg  [3];
    logic [UNIT_W-1:0]   r5_p, r5_q, r5_l;
    logic                r5_szero;
    logic [CH_W-1:0]     r5_alpha;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n5_prod[c] = r4_d * r4_w[c];
        end
    end

    // stage 6: channel value in unit scale
    logic [UNIT_W:0] n6_v [3];
    logic [UNIT_W:0] r6_v [3];
    logic [CH_W-1:0] r6_alpha;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r5_szero) begin
                n6_v[c] = {1'b0, r5_l};
            end else begin
                case (r5_seg[c])
                    SEG_RAMP: n6_v[c] = {1'b0, r5_p} + {1'b0, r5_hp[c]};
                    SEG_Q:    n6_v[c] = {1'b0, r5_q};
                    SEG_P:    n6_v[c] = {1'b0, r5_p};
                    default:  n6_v[c] = {1'b0, r5_p};
                endcase
            end
        end
    end

    // stage 7: output register
    logic [CH_W-1:0] r7_red, r7_green, r7_blue, r7_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_l     <= n1_l;
            r1_s     <= n1_s;
            r1_turn  <= i_turn;
            r1_alpha <= i_side.alpha;

            r2_ls    <= n2_prod[2*UNIT_W-2:FRAC];
            r2_l     <= r1_l;
            r2_s     <= r1_s;
            r2_turn  <= r1_turn;
            r2_alpha <= r1_alpha;

            r3_q     <= n3_q[UNIT_W-1:0];
            r3_p     <= n3_p[UNIT_W-1:0];
            r3_l     <= r2_l;
            r3_szero <= (r2_s == '0);
            r3_alpha <= r2_alpha;

            r4_d     <= r3_q - r3_p;
            r4_p     <= r3_p;
            r4_q     <= r3_q;
            r4_l     <= r3_l;
            r4_szero <= r3_szero;
            r4_alpha <= r3_alpha;

            r5_p     <= r4_p;
            r5_q     <= r4_q;
            r5_l     <= r4_l;
            r5_szero <= r4_szero;
            r5_alpha <= r4_alpha;

            r6_alpha <= r5_alpha;

            r7_red   <= to_chan(r6_v[0]);
            r7_green <= to_chan(r6_v[1]);
            r7_blue  <= to_chan(r6_v[2]);
            r7_alpha <= r6_alpha;

            for (int c = 0; c < 3; c++) begin
                r3_t[c]   <= n3_t[c];
                r4_w[c]   <= n4_w[c];
                r4_seg[c] <= n4_seg[c];
                r5_hp[c]  <= n5_prod[c][2*UNIT_W-2:FRAC];
                r5_seg[c] <= r4_seg[c];
                r6_v[c]   <= n6_v[c];
            end
        end
    end

    assign o_valid = r_vld[6];
    assign o_red   = r7_red;
    assign o_green = r7_green;
    assign o_blue  = r7_blue;
    assign o_alpha = r7_alpha;

endmodule
`default_nettype wire

// ===== design/hsl_color_shade.sv =====
`default_nettype none
// Register stages from an accepted input word to its output word:
//   front 3, two 17-stage dividers, hue stage 1, turn scale 1, back end 7.
// Throughput: one word per clock when not stalled; every stage is a register with a valid bit.
// A stall on a valid output word freezes the whole pipeline; o_stall follows it.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers
//   are not reset.
// ---------------------------------------------------------------------------
// hsl_color_shade: shade an RGBA pixel in HSL space
// RGB -> HSL, lightness and saturation scaled by a Q2.8 factor and clamped,
// HSL -> RGB with round to nearest; alpha passes straight through.
// ---------------------------------------------------------------------------
module hsl_color_shade import hcs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input word
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CH_W-1:0]   i_red_in,
    input  logic [CH_W-1:0]   i_green_in,
    input  logic [CH_W-1:0]   i_blue_in,
    input  logic [CH_W-1:0]   i_alpha_in,
    input  logic [FACT_W-1:0] i_shade_factor,
    // output word
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CH_W-1:0]   o_red_out,
    output logic [CH_W-1:0]   o_green_out,
    output logic [CH_W-1:0]   o_blue_out,
    output logic [CH_W-1:0]   o_alpha_out
);

    // Single advance enable: the pipeline moves unless a finished word sits
    // in the output register and the sink stalls it.
    logic w_en;
    assign o_stall = o_valid && i_stall;
    assign w_en    = !o_stall;

    // ---- front end: units, max/min, lightness, saturation operands ----
    logic                 w_f_vld;
    logic [DIV_NUM_W-1:0] w_f_num;
    logic [DIV_DEN_W-1:0] w_f_den;
    t_side                w_f_side;

    hcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .i_alpha (i_alpha_in),
        .i_fac   (i_shade_factor),
        .o_valid (w_f_vld),
        .o_num   (w_f_num),
        .o_den   (w_f_den),
        .o_side  (w_f_side)
    );

    // ---- saturation = delta / (sum or 2 - sum) ----
    logic               w_s_vld;
    logic [DIV_Q_W-1:0] w_s_quo;
    t_side              w_s_side;

    hcs_div u_div_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_vld),
        .i_num   (w_f_num),
        .i_den   (w_f_den),
        .i_side  (w_f_side),
        .o_valid (w_s_vld),
        .o_quo   (w_s_quo),
        .o_side  (w_s_side)
    );

    // ---- hue ratio = |diff| / delta; grey divides 0 by 1 ----
    t_side                w_r_in;
    logic [DIV_NUM_W-1:0] w_r_num;
    logic [DIV_DEN_W-1:0] w_r_den;
    logic                 w_r_vld;
    logic [DIV_Q_W-1:0]   w_ratio;
    t_side                w_r_side;

    always_comb begin
        w_r_in   = w_s_side;
        w_r_in.s = w_s_quo;
        w_r_num  = {w_s_side.dmag, {FRAC{1'b0}}};
        w_r_den  = (w_s_side.delta == '0) ? DIV_DEN_W'(1) : {1'b0, w_s_side.delta};
    end

    hcs_div u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_vld),
        .i_num   (w_r_num),
        .i_den   (w_r_den),
        .i_side  (w_r_in),
        .o_valid (w_r_vld),
        .o_quo   (w_ratio),
        .o_side  (w_r_side)
    );

    // ---- hue in degrees: sector base +/- 60 * ratio, wrapped into [0, 360) ----
    logic [DEG_W-1:0]        n_m60;
    logic [DEG_W-1:0]        n_base;
    logic signed [DEG_W+1:0] n_sdeg;
    logic [DEG_W-1:0]        r_deg;
    t_side                   r_h_side;
    logic                    r_h_vld;

    always_comb begin
        n_m60 = (DEG_W'(w_ratio) << 6) - (DEG_W'(w_ratio) << 2);
        case (w_r_side.sec)
            SEC_RED:   n_base = '0;
            SEC_GREEN: n_base = DEG_120;
            SEC_BLUE:  n_base = DEG_240;
            default:   n_base = '0;
        endcase
        if (w_r_side.neg) begin
            n_sdeg = $signed({2'b0, n_base}) - $signed({2'b0, n_m60});
        end else begin
            n_sdeg = $signed({2'b0, n_base}) + $signed({2'b0, n_m60});
        end
        if (n_sdeg < 0) begin
            n_sdeg = n_sdeg + $signed({2'b0, DEG_360});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (w_en) begin
            r_h_vld <= w_r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_deg    <= n_sdeg[DEG_W-1:0];
            r_h_side <= w_r_side;
        end
    end

    // ---- hue as a fraction of a turn = degrees / 360 ----
    // deg / 360 == (deg >> 3) / 45; the divide by 45 is a reciprocal multiply,
    // one register stage.
    localparam int DEG8_W = DEG_W - 3;
    localparam int TP_W   = DEG8_W + TURN_RECIP_W;

    logic [TP_W-1:0]   n_tprod;
    logic [UNIT_W-1:0] r_turn;
    t_side             r_t_side;
    logic              r_t_vld;

    assign n_tprod = TP_W'(r_deg[DEG_W-1:3]) * TP_W'(TURN_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else if (w_en) begin
            r_t_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_turn   <= n_tprod[TURN_SHIFT +: UNIT_W];
            r_t_side <= r_h_side;
        end
    end

    // ---- back end: shade, HSL -> RGB, output register ----
    hcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_t_vld),
        .i_side  (r_t_side),
        .i_turn  (r_turn),
        .o_valid (o_valid),
        .o_red   (o_red_out),
        .o_green (o_green_out),
        .o_blue  (o_blue_out),
        .o_alpha (o_alpha_out)
    );

endmodule
`default_nettype wire

// ===== design/hcs_chk.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hcs_chk: port-level checks for hsl_color_shade
// Output hold under stall, stall only with a pending word, reset behavior.
// ---------------------------------------------------------------------------
module hcs_chk import hcs_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [CH_W-1:0]   i_red_in,
    input logic [CH_W-1:0]   i_green_in,
    input logic [CH_W-1:0]   i_blue_in,
    input logic [CH_W-1:0]   i_alpha_in,
    input logic [FACT_W-1:0] i_shade_factor,
    input logic              o_valid,
    input logic              i_stall,
    input logic [CH_W-1:0]   o_red_out,
    input logic [CH_W-1:0]   o_green_out,
    input logic [CH_W-1:0]   o_blue_out,
    input logic [CH_W-1:0]   o_alpha_out
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red_out) && $stable(o_green_out)
            && $stable(o_blue_out) && $stable(o_alpha_out))
        else $error("output word changed while stalled");

    // the block only pushes back when a finished word is blocked
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid || !i_stall |-> !o_stall)
        else $error("input stalled with no blocked output word");

    // reset leaves no valid output word
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind hsl_color_shade hcs_chk u_hcs_chk (.*);
`default_nettype wire
